FILE: rtl/bast_pkg.sv
// Shared constants and types for the boxcar average slew tracker.
package bast_pkg;

   // Window length and converter width.
   localparam int WINDOW = 50;
   localparam int SAMPLE_BITS = 10;
   localparam int COUNT_BITS = 8;

   // Warmup register value after reset.
   localparam logic [COUNT_BITS-1:0] WARMUP_RESET = COUNT_BITS'(70);

   // Ring addressing and running sum width.
   localparam int POS_BITS = $clog2(WINDOW);
   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(WINDOW - 1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW);

   // Exact reciprocal for sum / WINDOW over every SUM_BITS value:
   // ceil(2^k / WINDOW) with k = SUM_BITS + ceil(log2(WINDOW)).
   localparam int RECIP_SHIFT = SUM_BITS + $clog2(WINDOW);
   localparam int RECIP_BITS = SUM_BITS + 1;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_BITS-1:0] RECIP_MULT = RECIP_FULL[RECIP_BITS-1:0];
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

   // Tracker outcome for one word.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] filtered;
      logic                   settled;
   } trk_result_type;

endpackage

FILE: rtl/bast_sample_window.sv
// Sample ring, running sum and reciprocal mean for the boxcar average.
module bast_sample_window
   import bast_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS-1:0] mean
);

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]      ring_valid_ff;
   logic [WINDOW-1:0]      ring_valid_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic [POS_BITS-1:0]    pos_ff;
   logic [POS_BITS-1:0]    pos_in;
   logic [POS_BITS-1:0]    next_pos;
   logic [SAMPLE_BITS-1:0] oldest;
   logic [PROD_BITS-1:0]   product;

   // The entry being replaced was read ahead when the position last moved.
   assign oldest   = rd_valid_ff ? rd_data_ff : '0;
   assign next_pos = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_BITS'(1);
   assign sum_in   = sum_ff - SUM_BITS'(oldest) + SUM_BITS'(sample);
   assign product  = PROD_BITS'(sum_in) * PROD_BITS'(RECIP_MULT);
   assign mean     = product[RECIP_SHIFT +: SAMPLE_BITS];

   always_comb begin
      ring_valid_in = ring_valid_ff;
      pos_in        = pos_ff;
      rd_valid_in   = rd_valid_ff;
      if (advance) begin
         ring_valid_in[pos_ff] = 1'b1;
         pos_in                = next_pos;
         rd_valid_in           = ring_valid_ff[next_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         pos_ff        <= '0;
      end else begin
         ring_valid_ff <= ring_valid_in;
         rd_valid_ff   <= rd_valid_in;
         pos_ff        <= pos_in;
         if (advance) begin
            sum_ff <= sum_in;
         end
      end
   end

   // Write the new sample and read ahead the entry the next word replaces.
   always_ff @(posedge clock) begin
      if (advance) begin
         ring_mem[pos_ff] <= sample;
         rd_data_ff       <= ring_mem[next_pos];
      end
   end

endmodule

FILE: rtl/bast_slew_tracker.sv
// Warmup counter and slew-limited tracker.
module bast_slew_tracker
   import bast_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [COUNT_BITS-1:0]  warmup_samples,
   input  logic [SAMPLE_BITS-1:0] mean,
   output trk_result_type         result
);

   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [SAMPLE_BITS-1:0] tracker_ff;
   logic [SAMPLE_BITS-1:0] tracker_in;
   logic                   loaded_ff;
   logic                   loaded_in;
   logic                   settled;
   logic [SAMPLE_BITS-1:0] base;

   assign settled = count_ff >= warmup_samples;
   // On the first settled word the tracker starts from the mean itself.
   assign base    = loaded_ff ? tracker_ff : mean;

   always_comb begin
      count_in   = count_ff;
      tracker_in = tracker_ff;
      loaded_in  = loaded_ff;
      if (advance) begin
         if (settled) begin
            count_in  = warmup_samples;
            loaded_in = 1'b1;
            priority if (mean > base) begin
               tracker_in = base + SAMPLE_BITS'(1);
            end else if (mean < base) begin
               tracker_in = base - SAMPLE_BITS'(1);
            end else begin
               tracker_in = base;
            end
         end else begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         tracker_ff <= '0;
         loaded_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         tracker_ff <= tracker_in;
         loaded_ff  <= loaded_in;
      end
   end

   assign result.filtered = settled ? tracker_in : mean;
   assign result.settled  = settled;

endmodule

FILE: rtl/boxcar_average_slew_tracker_unit.sv
// Top level of the boxcar average slew tracker: input register, datapath, result register.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_sample
//   rsp_      out        rsp_valid/rsp_stall   rsp_mean_value, rsp_filtered_value, rsp_settled
//   csr_      in         csr_wr_en             csr_wr_data (warmup_samples)
//
// One word is accepted per cycle while req_stall is low; each word passes through the
// input register and then the result register.
// The throughput is set by the single ring write port and the running-sum update,
// which together take at most one sample per cycle.
// Reset is synchronous and active high; ring entries start out invalid and read as zero,
// so no clearing pass is needed and a word can be taken right after reset.
// A stalled result holds; the input register then holds too and req_stall rises.
module boxcar_average_slew_tracker_unit
   import bast_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_mean_value,
   output logic [SAMPLE_BITS-1:0] rsp_filtered_value,
   output logic                   rsp_settled,
   input  logic                   csr_wr_en,
   input  logic [COUNT_BITS-1:0]  csr_wr_data
);

   // Configuration register.
   logic [COUNT_BITS-1:0]  warmup_ff;

   // Input register stage.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // Result register stage.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [SAMPLE_BITS-1:0] filtered_ff;
   logic                   settled_ff;

   logic                   advance;
   logic [SAMPLE_BITS-1:0] mean;
   trk_result_type         trk_result;

   // The word in the input register moves on whenever the result register is free
   // or is being emptied in this same cycle. All state updates follow that move.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff    <= WARMUP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            warmup_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_sample_ff <= req_sample;
      end
      if (advance) begin
         mean_ff     <= mean;
         filtered_ff <= trk_result.filtered;
         settled_ff  <= trk_result.settled;
      end
   end

   bast_sample_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_sample_ff),
      .mean    (mean)
   );

   bast_slew_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .warmup_samples (warmup_ff),
      .mean           (mean),
      .result         (trk_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_value     = mean_ff;
   assign rsp_filtered_value = filtered_ff;
   assign rsp_settled        = settled_ff;

`ifndef ASSERT_OFF
   // A word that moves out of the input register always lands in the result register.
   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced word did not reach the result register");

   // A held word in the input register is neither dropped nor altered.
   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_sample_ff)))
      else $error("held input word was lost or changed");

   // The result register changes only when a new word is loaded.
   a_result_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !advance) |=>
         ($stable(mean_ff) && $stable(filtered_ff) && $stable(settled_ff)))
      else $error("result register changed without a new word");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the boxcar average slew tracker unit.
module testbench
   import bast_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // The unit holds a word only in its input and result registers, so a handful of
   // cycles after the last result is enough to see whether anything stray comes out.
   localparam int TAIL_CYCLES = 8;
   // The worst quiet stretch in a correct run is a long sender gap plus a long
   // receiver stall. This limit leaves ample margin.
   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
   localparam int PHASES = 8;
   localparam int SCRIPT_ROWS = 23;

   // One result word as the unit presents it.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] mean;
      logic [SAMPLE_BITS-1:0] filt;
      logic                   settled;
   } avg_word_type;

   // A directed row either sends a sample word or rewrites the warmup register.
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [SAMPLE_BITS-1:0] value;
      logic                   check;
      avg_word_type           want;
   } script_row_type;

   // Shapes of the random sample stream, each held for a burst of words.
   typedef enum int {SRC_LEVEL, SRC_NOISE, SRC_RAIL, SRC_HOLD} src_kind_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_mean_value;
   logic [SAMPLE_BITS-1:0] rsp_filtered_value;
   logic                   rsp_settled;
   logic                   csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0]  csr_wr_data = '0;

   // Our own copy of the filter state, starting from its reset values.
   logic [SAMPLE_BITS-1:0] window_buf [WINDOW] = '{default: '0};
   logic [SUM_BITS-1:0]    window_sum = '0;
   logic [POS_BITS-1:0]    slot = '0;
   logic [COUNT_BITS-1:0]  warm_count = '0;
   logic [COUNT_BITS-1:0]  warm_limit = WARMUP_RESET;
   logic [SAMPLE_BITS-1:0] track_val = '0;
   logic                   track_live = 1'b0;

   // Results still owed by the unit, oldest first.
   avg_word_type pending_results [$];

   int faults = 0;
   int words_sent = 0;
   int results_seen = 0;
   int settled_seen = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;
   int calm_words = 0;
   int stall_left = 0;
   int calm_left = 0;
   int stall_roll;

   // Directed words. The first rows run with the reset warmup of 70, so the
   // early means carry the zeros of the cleared ring. Dropping warmup to 0
   // settles the very next word, which loads the tracker with the mean; the
   // word after that shows the first one-count slew step. Raising warmup to 4
   // after settling makes words unsettled again without reloading the tracker,
   // and 255 is the top of the register. The last rows toggle every sample bit.
   script_row_type script [SCRIPT_ROWS] = '{
      '{ROW_WORD, 10'd1023, 1'b1, '{10'd20, 10'd20, 1'b0}},
      '{ROW_WORD, 10'd0,    1'b1, '{10'd20, 10'd20, 1'b0}},
      '{ROW_WORD, 10'd1023, 1'b1, '{10'd40, 10'd40, 1'b0}},
      '{ROW_CSR,  10'd0,    1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b1, '{10'd61, 10'd61, 1'b1}},
      '{ROW_WORD, 10'd1023, 1'b1, '{10'd81, 10'd62, 1'b1}},
      '{ROW_WORD, 10'd0,    1'b0, '0},
      '{ROW_WORD, 10'd0,    1'b0, '0},
      '{ROW_WORD, 10'd1,    1'b0, '0},
      '{ROW_WORD, 10'd1022, 1'b0, '0},
      '{ROW_CSR,  10'd4,    1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_CSR,  10'd255,  1'b0, '0},
      '{ROW_WORD, 10'd512,  1'b0, '0},
      '{ROW_WORD, 10'd0,    1'b0, '0},
      '{ROW_WORD, 10'd1023, 1'b0, '0},
      '{ROW_WORD, 10'd341,  1'b0, '0},
      '{ROW_WORD, 10'd682,  1'b0, '0}
   };

   boxcar_average_slew_tracker_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_settled        (rsp_settled),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Pushes one sample through the ring and the tracker and returns the word
   // the unit should produce for it.
   function automatic avg_word_type boxcar_track(input logic [SAMPLE_BITS-1:0] s);
      avg_word_type           r;
      logic [SAMPLE_BITS-1:0] avg;
      window_sum = window_sum - SUM_BITS'(window_buf[slot]) + SUM_BITS'(s);
      window_buf[slot] = s;
      slot = (slot == POS_LAST) ? '0 : slot + 1'b1;
      avg = SAMPLE_BITS'(window_sum / WINDOW);
      r.mean = avg;
      r.filt = avg;
      r.settled = 1'b0;
      // The warmup test uses the count from before this word.
      if (warm_count >= warm_limit) begin
         if (!track_live) begin
            track_val = avg;
            track_live = 1'b1;
         end
         if (avg > track_val) track_val = track_val + 1'b1;
         else if (avg < track_val) track_val = track_val - 1'b1;
         r.filt = track_val;
         r.settled = 1'b1;
         warm_count = warm_limit;
      end else begin
         warm_count = warm_count + 1'b1;
      end
      return r;
   endfunction

   task automatic report_fault(input string what, input avg_word_type want,
                               input avg_word_type got);
      faults++;
      if (faults <= REPORT_LIMIT) begin
         $display("%s at result %0d: expected mean %0d filtered %0d settled %0d,",
                  what, results_seen, want.mean, want.filt, want.settled);
         $display("   got mean %0d filtered %0d settled %0d",
                  got.mean, got.filt, got.settled);
      end
   endtask

   // Offers one word and holds it until the unit takes it. The expectation is
   // either the typed one from the table or the predicted one; the predictor
   // state advances in both cases.
   task automatic send_word(input logic [SAMPLE_BITS-1:0] s, input logic typed,
                            input avg_word_type want);
      avg_word_type calc;
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      calc = boxcar_track(s);
      pending_results.push_back(typed ? want : calc);
      words_sent++;
   endtask

   // Idles the sender between words: mostly back to back, sometimes a short or
   // a long gap, and now and then a stretch of words with no gaps at all. The
   // valid is only lowered when time actually passes before the next word.
   task automatic pace_sender();
      int gap;
      int roll;
      gap = 0;
      if (calm_words != 0) begin
         calm_words--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55) gap = 0;
         else if (roll < 85) gap = $urandom_range(1, 3);
         else if (roll < 93) gap = $urandom_range(8, 40);
         else calm_words = $urandom_range(20, 80);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending until every owed result has come back, then lets the
   // pipeline settle for a few more cycles.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // The warmup register is only rewritten with the unit idle.
   task automatic write_warmup(input logic [COUNT_BITS-1:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      warm_limit = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   // Stimulus: directed table first, then random phases, each under its own
   // warmup setting. The reset value, both register extremes and a value of
   // one are always among them; two more are picked at random.
   initial begin
      int           warm_plan [PHASES];
      int           ph;
      int           k;
      int           lvl;
      int           v;
      int           burst_left;
      src_kind_type src;
      warm_plan = '{255, 0, 1, 70, 0, 2, 128, 0};
      warm_plan[4] = $urandom_range(3, 40);
      warm_plan[7] = $urandom_range(0, 255);
      burst_left = 0;
      lvl = 0;
      src = SRC_NOISE;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            write_warmup(COUNT_BITS'(script[i].value));
         end else begin
            send_word(script[i].value, script[i].check, script[i].want);
            pace_sender();
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         write_warmup(COUNT_BITS'(warm_plan[ph]));
         // Each phase runs long enough to get past its warmup and track a while.
         for (k = 0; k < 80 + warm_plan[ph]; k++) begin
            if (burst_left == 0) begin
               src = src_kind_type'($urandom_range(0, 3));
               burst_left = $urandom_range(1, 40);
               lvl = $urandom_range(0, FULL_SCALE);
            end
            burst_left--;
            case (src)
               SRC_LEVEL: begin
                  // A noisy plateau lets the tracker catch up and dither.
                  v = lvl + int'($urandom_range(0, 6)) - 3;
                  if (v < 0) v = 0;
                  if (v > FULL_SCALE) v = FULL_SCALE;
               end
               SRC_NOISE: v = $urandom_range(0, FULL_SCALE);
               SRC_RAIL: v = $urandom_range(0, 1) ? FULL_SCALE : 0;
               default: v = lvl;
            endcase
            send_word(SAMPLE_BITS'(v), 1'b0, '0);
            // Occasionally the sender waits for the unit to empty completely.
            if ($urandom_range(0, 199) == 0) drain_results();
            else pace_sender();
         end
      end

      drain_results();
      faults += pending_results.size();
      $display("Sent %0d words under %0d warmup settings, checked %0d results.",
               words_sent, csr_writes, results_seen);
      $display("%0d results were settled; %0d mismatches in all.", settled_seen, faults);
      if (faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Receiver stalls: mostly none, short bursts, a few long holds, and calm
   // stretches where every result is taken at once.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         calm_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left != 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 60) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 85) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else if (stall_roll < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(5, 30);
         end else begin
            rsp_stall <= 1'b0;
            calm_left = $urandom_range(20, 80);
         end
      end
   end

   // Result checker: every word taken from the unit is matched field by
   // field against the oldest owed result.
   always @(posedge clock) begin
      avg_word_type got;
      avg_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mean = rsp_mean_value;
         got.filt = rsp_filtered_value;
         got.settled = rsp_settled;
         results_seen++;
         if (got.settled === 1'b1) settled_seen++;
         if (pending_results.size() == 0) begin
            report_fault("Unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.mean !== want.mean || got.filt !== want.filt
                || got.settled !== want.settled) begin
               report_fault("Mismatch", want, got);
            end
         end
      end
   end

   // Watchdog: a run that stops moving words on both channels is a hang.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/bast_pkg.sv
rtl/bast_sample_window.sv
rtl/bast_slew_tracker.sv
rtl/boxcar_average_slew_tracker_unit.sv
tb/testbench.sv
